@@ src/poram_pkg.sv @@
package poram_pkg;

  localparam int unsigned BLOCK_ID_BITS = 6;
  localparam int unsigned NUM_BLOCKS    = 64;
  localparam int unsigned SLOT_ID_BITS  = 7;
  localparam logic [SLOT_ID_BITS-1:0] DUMMY_ID = 7'd64;
  localparam int unsigned LEAF_IN_BITS  = 3;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the request and remap the block
    logic get_leaf;    // latch the block's old leaf from the leaf map read
    logic rd_slot;     // fetch one tree slot
    logic put_slot;    // insert the fetched slot into the stash
    logic put_write;   // insert the write payload into the stash
    logic find_req;    // look up the requested block in the stash
    logic pick_id;     // test one block id for eviction at the current level
    logic wr_slot;     // write one slot of the current bucket
    logic clr_pick;    // clear the pick list for a new level
    logic done;        // result is ready
  } poram_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pick_full;
  } poram_sts_t;

endpackage

@@ src/poram_ctrl.sv @@
module poram_ctrl import poram_pkg::*; #(
  parameter int unsigned TREE_LEVELS      = 4,
  parameter int unsigned SLOTS_PER_BUCKET = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       out_free,
  input  poram_sts_t sts,
  output poram_cmd_t cmd,
  output logic       busy,
  output logic [$clog2(TREE_LEVELS)-1:0]     level,
  output logic [$clog2(SLOTS_PER_BUCKET+1)-1:0] slot,
  output logic [BLOCK_ID_BITS-1:0]           scan_id,
  output logic [BLOCK_ID_BITS-1:0]           scan_nxt
);

  localparam int unsigned LVW = $clog2(TREE_LEVELS);
  localparam int unsigned SW  = $clog2(SLOTS_PER_BUCKET + 1);
  localparam logic [LVW-1:0] LAST_LEVEL = LVW'(TREE_LEVELS - 1);
  localparam logic [SW-1:0]  LAST_SLOT  = SW'(SLOTS_PER_BUCKET - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_RDS   = 4'd2;
  localparam logic [3:0] S_PUTS  = 4'd3;
  localparam logic [3:0] S_WPUT  = 4'd4;
  localparam logic [3:0] S_FIND  = 4'd5;
  localparam logic [3:0] S_PICK  = 4'd6;
  localparam logic [3:0] S_WRS   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]     state_r, state_nxt;
  logic [LVW-1:0] level_r, level_nxt;
  logic [SW-1:0]  slot_r, slot_nxt;
  logic [BLOCK_ID_BITS-1:0] id_r, id_nxt;

  assign busy     = (state_r != S_IDLE);
  assign level    = level_r;
  assign slot     = slot_r;
  assign scan_id  = id_r;
  // The leaf map is read with the next id, so its registered output matches the id under test.
  assign scan_nxt = id_nxt;

  always_comb begin
    state_nxt = state_r;
    level_nxt = level_r;
    slot_nxt  = slot_r;
    id_nxt    = id_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.get_leaf = 1'b1;
        level_nxt    = '0;
        slot_nxt     = '0;
        state_nxt    = S_RDS;
      end
      S_RDS: begin
        cmd.rd_slot = 1'b1;
        state_nxt   = S_PUTS;
      end
      S_PUTS: begin
        cmd.put_slot = 1'b1;
        state_nxt    = S_RDS;
        if (slot_r == LAST_SLOT) begin
          slot_nxt = '0;
          if (level_r == LAST_LEVEL) state_nxt = S_WPUT;
          else level_nxt = level_r + LVW'(1);
        end else begin
          slot_nxt = slot_r + SW'(1);
        end
      end
      S_WPUT: begin
        cmd.put_write = 1'b1;
        state_nxt     = S_FIND;
      end
      S_FIND: begin
        cmd.find_req = 1'b1;
        cmd.clr_pick = 1'b1;
        level_nxt    = LAST_LEVEL;
        id_nxt       = '0;
        state_nxt    = S_PICK;
      end
      S_PICK: begin
        if (sts.pick_full) begin
          slot_nxt  = '0;
          state_nxt = S_WRS;
        end else begin
          cmd.pick_id = 1'b1;
          id_nxt      = id_r + BLOCK_ID_BITS'(1);
          if (id_r == BLOCK_ID_BITS'(NUM_BLOCKS - 1)) begin
            slot_nxt  = '0;
            state_nxt = S_WRS;
          end
        end
      end
      S_WRS: begin
        cmd.wr_slot = 1'b1;
        if (slot_r == LAST_SLOT) begin
          if (level_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            level_nxt    = level_r - LVW'(1);
            id_nxt       = '0;
            cmd.clr_pick = 1'b1;
            state_nxt    = S_PICK;
          end
        end else begin
          slot_nxt = slot_r + SW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.done  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      level_r <= '0;
      slot_r  <= '0;
      id_r    <= '0;
    end else begin
      state_r <= state_nxt;
      level_r <= level_nxt;
      slot_r  <= slot_nxt;
      id_r    <= id_nxt;
    end
  end

endmodule

@@ src/poram_dp.sv @@
module poram_dp import poram_pkg::*; #(
  parameter int unsigned TREE_LEVELS      = 4,
  parameter int unsigned SLOTS_PER_BUCKET = 4,
  parameter int unsigned PAYLOAD_BITS     = 64,
  parameter int unsigned STASH_ENTRIES    = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  poram_cmd_t cmd,
  input  logic [$clog2(TREE_LEVELS)-1:0]        level,
  input  logic [$clog2(SLOTS_PER_BUCKET+1)-1:0] slot,
  input  logic [BLOCK_ID_BITS-1:0]              scan_id,
  input  logic [BLOCK_ID_BITS-1:0]              scan_nxt,
  input  logic                     req_op,
  input  logic [BLOCK_ID_BITS-1:0] req_id,
  input  logic [63:0]              req_wdata,
  input  logic [LEAF_IN_BITS-1:0]  req_leaf,
  output poram_sts_t               sts,
  output logic [63:0]              read_data,
  output logic                     found,
  output logic                     overflow
);

  localparam int unsigned LB   = TREE_LEVELS - 1;            // leaf bits
  localparam int unsigned LBW  = (LB > 0) ? LB : 1;
  localparam int unsigned BKW  = TREE_LEVELS;                // bucket index bits
  localparam int unsigned SLW  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int unsigned TAW  = BKW + SLW;
  localparam int unsigned TDEP = (1 << BKW) * (1 << SLW);
  localparam int unsigned SEW  = (STASH_ENTRIES > 1) ? $clog2(STASH_ENTRIES) : 1;
  localparam int unsigned PCW  = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int unsigned LVW  = $clog2(TREE_LEVELS);
  localparam int unsigned SW   = $clog2(SLOTS_PER_BUCKET + 1);

  // Tree memory; valid bits stand in for the dummy reset.
  logic [SLOT_ID_BITS-1:0] tid_mem [TDEP];
  logic [PAYLOAD_BITS-1:0] tdat_mem [TDEP];
  logic [TDEP-1:0]         tval_r;

  // Leaf map memory; a block never remapped reads as leaf 0.
  logic [LBW-1:0]          lm_mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0]   lm_val_r;
  logic [LBW-1:0]          lm_dat_r;
  logic                    lm_hit_r;
  logic [LBW-1:0]          lm_leaf;
  logic [BLOCK_ID_BITS-1:0] lm_addr;
  logic [LBW+LEAF_IN_BITS-1:0] leaf_ext;
  logic [LBW-1:0]          new_leaf;

  logic                    stv_r [STASH_ENTRIES];
  logic [BLOCK_ID_BITS-1:0] sid_r [STASH_ENTRIES];
  logic [PAYLOAD_BITS-1:0] sdat_r [STASH_ENTRIES];

  logic [LBW-1:0]          old_leaf_r;
  logic                    op_r;
  logic [BLOCK_ID_BITS-1:0] bid_r;
  logic [PAYLOAD_BITS-1:0] wdata_r;
  logic [SLOT_ID_BITS-1:0] rd_id_r;
  logic [PAYLOAD_BITS-1:0] rd_dat_r;
  logic                    rd_val_r;
  logic                    ovf_r;
  logic [PAYLOAD_BITS-1:0] rdata_r;
  logic                    found_r;

  logic [PCW-1:0]          pcnt_r;
  logic [BLOCK_ID_BITS-1:0] pid_r [SLOTS_PER_BUCKET];
  logic [PAYLOAD_BITS-1:0] pdat_r [SLOTS_PER_BUCKET];

  function automatic logic [BKW-1:0] bucket_of(input logic [LVW-1:0] lv,
                                               input logic [LBW-1:0] lf);
    logic [BKW-1:0] full;
    full = {1'b1, lf[LB-1:0]};
    return BKW'(full >> (LB - lv));
  endfunction

  logic [BKW-1:0] cur_bkt;
  logic [TAW-1:0] rd_addr, wr_addr;
  logic [SW-1:0]  wslot;
  assign cur_bkt = bucket_of(level, old_leaf_r);
  assign rd_addr = {cur_bkt, SLW'(slot)};
  assign wr_addr = rd_addr;
  assign wslot   = slot;

  assign leaf_ext = {{LBW{1'b0}}, req_leaf};
  assign new_leaf = leaf_ext[LBW-1:0];
  assign lm_addr  = cmd.load ? req_id : scan_nxt;
  assign lm_leaf  = lm_hit_r ? lm_dat_r : '0;

  always_ff @(posedge clk) begin
    lm_dat_r <= lm_mem[lm_addr];
    lm_hit_r <= lm_val_r[lm_addr];
    if (cmd.load) lm_mem[req_id] <= new_leaf;
  end

  // Stash insert: one key, matched or first free entry.
  logic                    ins_en;
  logic [BLOCK_ID_BITS-1:0] ins_id;
  logic [PAYLOAD_BITS-1:0] ins_dat;
  logic                    hit, has_free;
  logic [SEW-1:0]          hit_idx, free_idx;

  always_comb begin
    ins_en  = 1'b0;
    ins_id  = rd_id_r[BLOCK_ID_BITS-1:0];
    ins_dat = rd_dat_r;
    if (cmd.put_slot) begin
      ins_en = rd_val_r && (rd_id_r < DUMMY_ID);
    end else if (cmd.put_write) begin
      ins_en  = (op_r == OP_WRITE);
      ins_id  = bid_r;
      ins_dat = wdata_r;
    end else if (cmd.find_req) begin
      ins_id = bid_r;
    end else if (cmd.pick_id) begin
      ins_id = scan_id;
    end
  end

  always_comb begin
    hit = 1'b0; hit_idx = '0; has_free = 1'b0; free_idx = '0;
    for (int i = STASH_ENTRIES - 1; i >= 0; i--) begin
      if (stv_r[i] && sid_r[i] == ins_id) begin
        hit = 1'b1; hit_idx = SEW'(i);
      end
      if (!stv_r[i]) begin
        has_free = 1'b1; free_idx = SEW'(i);
      end
    end
  end

  logic pick_ok;
  assign pick_ok = hit && (bucket_of(level, lm_leaf) == cur_bkt);
  assign sts.pick_full = (pcnt_r == PCW'(SLOTS_PER_BUCKET));

  always_ff @(posedge clk) begin
    if (cmd.rd_slot) begin
      rd_id_r  <= tid_mem[rd_addr];
      rd_dat_r <= tdat_mem[rd_addr];
      rd_val_r <= tval_r[rd_addr];
    end
    if (cmd.wr_slot) begin
      if (wslot < pcnt_r) begin
        tid_mem[wr_addr]  <= SLOT_ID_BITS'(pid_r[SLW'(pcnt_r - PCW'(1) - PCW'(wslot))]);
        tdat_mem[wr_addr] <= pdat_r[SLW'(pcnt_r - PCW'(1) - PCW'(wslot))];
      end else begin
        tid_mem[wr_addr]  <= DUMMY_ID;
        tdat_mem[wr_addr] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= req_op;
      bid_r   <= req_id;
      wdata_r <= req_wdata[PAYLOAD_BITS-1:0];
    end
    if (ins_en) begin
      if (hit) sdat_r[hit_idx] <= ins_dat;
      else if (has_free) begin
        sid_r[free_idx]  <= ins_id;
        sdat_r[free_idx] <= ins_dat;
      end
    end
    if (cmd.find_req) begin
      found_r <= hit;
      rdata_r <= hit ? sdat_r[hit_idx] : '0;
    end
    if (cmd.pick_id && pick_ok) begin
      pid_r[SLW'(pcnt_r)]  <= scan_id;
      pdat_r[SLW'(pcnt_r)] <= sdat_r[hit_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tval_r     <= '0;
      lm_val_r   <= '0;
      ovf_r      <= 1'b0;
      pcnt_r     <= '0;
      old_leaf_r <= '0;
      for (int i = 0; i < STASH_ENTRIES; i++) stv_r[i] <= 1'b0;
    end else begin
      if (cmd.load) begin
        lm_val_r[req_id] <= 1'b1;
        ovf_r            <= 1'b0;
      end
      if (cmd.get_leaf) old_leaf_r <= lm_leaf;
      if (cmd.wr_slot) tval_r[wr_addr] <= 1'b1;
      if (ins_en && !hit) begin
        if (has_free) stv_r[free_idx] <= 1'b1;
        else          ovf_r <= 1'b1;
      end
      if (cmd.clr_pick) pcnt_r <= '0;
      else if (cmd.pick_id && pick_ok) begin
        pcnt_r <= pcnt_r + PCW'(1);
        stv_r[hit_idx] <= 1'b0;
      end
    end
  end

  assign read_data = 64'(rdata_r);
  assign found     = found_r;
  assign overflow  = ovf_r;

endmodule

@@ src/path_oram_access.sv @@
// Path ORAM access block.
// Requests enter on the in_ stream: tdata holds opcode, block_id, write_data
// and fresh_leaf. Each request yields exactly one result on the out_ stream:
// tdata holds read_data, found and stash_overflow.
// One request is processed at a time. After acceptance the block fetches the
// old leaf, moves the blocks on the path into the stash, inserts the write
// payload on writes and looks up the requested block, then for each level
// from the leaf up to the root scans block ids against the stash and writes
// back the bucket's slots. The id scan takes most of the time and ends early
// once the bucket of its level is full. in_tready returns in the cycle that
// the result appears on out_tdata, so a new request is accepted only after
// the previous one has finished.
// The result sits in an output register and holds while the receiver stalls;
// a finished request waits until that register has drained.
// After reset the tree holds only dummies, every block maps to leaf 0, the
// stash is empty, and no clearing pass is needed.
module path_oram_access import poram_pkg::*; #(
  parameter int unsigned TREE_LEVELS      = 4,
  parameter int unsigned SLOTS_PER_BUCKET = 4,
  parameter int unsigned PAYLOAD_BITS     = 64,
  parameter int unsigned STASH_ENTRIES    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // opcode, block_id[6], write_data[64], fresh_leaf[3], pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // read_data[64], found, stash_overflow, pad
);

  poram_cmd_t cmd;
  poram_sts_t sts;
  logic       busy;
  logic [$clog2(TREE_LEVELS)-1:0]        level;
  logic [$clog2(SLOTS_PER_BUCKET+1)-1:0] slot;
  logic [BLOCK_ID_BITS-1:0]              scan_id;
  logic [BLOCK_ID_BITS-1:0]              scan_nxt;
  logic [63:0] read_data;
  logic        found, overflow;
  logic        out_valid_r;
  logic [71:0] out_data_r;

  assign in_tready  = rst_n && !busy;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  poram_ctrl #(
    .TREE_LEVELS(TREE_LEVELS), .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)
  ) u_ctrl (
    .clk, .rst_n,
    .start    (in_tvalid && in_tready),
    .out_free (!out_valid_r || out_tready),
    .sts, .cmd, .busy, .level, .slot, .scan_id, .scan_nxt
  );

  poram_dp #(
    .TREE_LEVELS(TREE_LEVELS), .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET),
    .PAYLOAD_BITS(PAYLOAD_BITS), .STASH_ENTRIES(STASH_ENTRIES)
  ) u_dp (
    .clk, .rst_n, .cmd, .level, .slot, .scan_id, .scan_nxt,
    .req_op    (in_tdata[0]),
    .req_id    (in_tdata[6:1]),
    .req_wdata (in_tdata[70:7]),
    .req_leaf  (in_tdata[73:71]),
    .sts, .read_data, .found, .overflow
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) out_data_r <= {6'd0, overflow, found, read_data};
  end

endmodule
